// File: rtl/core/phfx_pkg.sv
package phfx_pkg;

   localparam int unsigned ADDR_WIDTH = 64;
   localparam int unsigned PORT_WIDTH = 16;

   localparam logic [15:0] ETHER_IPV4 = 16'h0800;
   localparam logic [15:0] ETHER_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

   // Fixed header offsets, in bytes from the start of the frame.
   localparam logic [15:0] POS_ETHER_HI   = 16'd12;
   localparam logic [15:0] POS_ETHER_LO   = 16'd13;
   localparam logic [15:0] POS_L3_START   = 16'd14;
   localparam logic [15:0] POS_V4_PROTO   = 16'd23;
   localparam logic [15:0] POS_V4_SRC     = 16'd26;
   localparam logic [15:0] POS_V4_DST     = 16'd30;
   localparam logic [15:0] POS_V4_END     = 16'd34;
   localparam logic [15:0] POS_V6_PROTO   = 16'd20;
   localparam logic [15:0] POS_V6_SRC_HI  = 16'd22;
   localparam logic [15:0] POS_V6_SRC_LO  = 16'd30;
   localparam logic [15:0] POS_V6_DST_HI  = 16'd38;
   localparam logic [15:0] POS_V6_DST_LO  = 16'd46;
   localparam logic [15:0] POS_V6_END     = 16'd54;
   localparam logic [3:0]  IHL_MIN        = 4'd5;
   localparam logic [7:0]  TCP_HDR_LEN    = 8'd20;
   localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;

   typedef enum logic [1:0] {
      L3_NONE = 2'd0,
      L3_IPV4 = 2'd1,
      L3_IPV6 = 2'd2
   } l3_kind_type;

   typedef enum logic [1:0] {
      L4_NONE = 2'd0,
      L4_TCP  = 2'd1,
      L4_UDP  = 2'd2
   } l4_kind_type;

   typedef struct packed {
      l3_kind_type             l3_kind;
      l4_kind_type             l4_kind;
      logic [ADDR_WIDTH-1:0]   src_addr_high;
      logic [ADDR_WIDTH-1:0]   src_addr_low;
      logic [ADDR_WIDTH-1:0]   dst_addr_high;
      logic [ADDR_WIDTH-1:0]   dst_addr_low;
      logic [PORT_WIDTH-1:0]   src_port;
      logic [PORT_WIDTH-1:0]   dst_port;
   } result_type;

endpackage

// File: rtl/core/phfx_if.sv
interface phfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       end_of_frame;

   modport source (output valid, output frame_byte, output end_of_frame, input ready);
   modport sink (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface phfx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  l3_kind;
   logic [1:0]  l4_kind;
   logic [63:0] src_addr_high;
   logic [63:0] src_addr_low;
   logic [63:0] dst_addr_high;
   logic [63:0] dst_addr_low;
   logic [15:0] src_port;
   logic [15:0] dst_port;

   modport source (output valid, output l3_kind, output l4_kind, output src_addr_high,
                   output src_addr_low, output dst_addr_high, output dst_addr_low,
                   output src_port, output dst_port, input ready);
   modport sink (input valid, input l3_kind, input l4_kind, input src_addr_high,
                 input src_addr_low, input dst_addr_high, input dst_addr_low,
                 input src_port, input dst_port, output ready);
endinterface

// File: rtl/core/phfx_capture.sv
module phfx_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [7:0]             frame_byte,
   input  logic                   end_of_frame,
   output phfx_pkg::result_type   result
);
   import phfx_pkg::*;

   logic [15:0]           offset_ff, offset_in;
   logic [15:0]           ether_ff, ether_in;
   logic [7:0]            proto_ff, proto_in;
   logic [3:0]            ihl_ff, ihl_in;
   logic [ADDR_WIDTH-1:0] src_hi_ff, src_hi_in, src_lo_ff, src_lo_in;
   logic [ADDR_WIDTH-1:0] dst_hi_ff, dst_hi_in, dst_lo_ff, dst_lo_in;
   logic [PORT_WIDTH-1:0] port0_ff, port0_in, port1_ff, port1_in;
   logic [15:0]           port_base;
   logic [15:0]           l4_pos;
   logic                  has_l4;

   // Field capture for the byte at the current offset.
   always_comb begin
      ether_in  = ether_ff;
      proto_in  = proto_ff;
      ihl_in    = ihl_ff;
      src_hi_in = src_hi_ff;
      src_lo_in = src_lo_ff;
      dst_hi_in = dst_hi_ff;
      dst_lo_in = dst_lo_ff;
      port0_in  = port0_ff;
      port1_in  = port1_ff;
      port_base = POS_V6_END;
      if (ether_ff == ETHER_IPV4) begin
         port_base = POS_L3_START + {10'd0, ihl_ff, 2'b00};
      end

      if (offset_ff == POS_ETHER_HI || offset_ff == POS_ETHER_LO) begin
         ether_in = {ether_ff[7:0], frame_byte};
      end else if (offset_ff >= POS_L3_START) begin
         if (ether_ff == ETHER_IPV4) begin
            if (offset_ff == POS_L3_START) begin
               ihl_in = frame_byte[3:0];
            end else if (offset_ff == POS_V4_PROTO) begin
               proto_in = frame_byte;
            end else if (offset_ff >= POS_V4_SRC && offset_ff < POS_V4_DST) begin
               src_lo_in = {src_lo_ff[ADDR_WIDTH-9:0], frame_byte};
            end else if (offset_ff >= POS_V4_DST && offset_ff < POS_V4_END) begin
               dst_lo_in = {dst_lo_ff[ADDR_WIDTH-9:0], frame_byte};
            end
            // A header length below five words carries no transport header.
            if (ihl_ff >= IHL_MIN && offset_ff >= POS_V4_END) begin
               if (offset_ff == port_base || offset_ff == port_base + 16'd1) begin
                  port0_in = {port0_ff[7:0], frame_byte};
               end else if (offset_ff == port_base + 16'd2 ||
                            offset_ff == port_base + 16'd3) begin
                  port1_in = {port1_ff[7:0], frame_byte};
               end
            end
         end else if (ether_ff == ETHER_IPV6) begin
            if (offset_ff == POS_V6_PROTO) begin
               proto_in = frame_byte;
            end else if (offset_ff >= POS_V6_SRC_HI && offset_ff < POS_V6_SRC_LO) begin
               src_hi_in = {src_hi_ff[ADDR_WIDTH-9:0], frame_byte};
            end else if (offset_ff >= POS_V6_SRC_LO && offset_ff < POS_V6_DST_HI) begin
               src_lo_in = {src_lo_ff[ADDR_WIDTH-9:0], frame_byte};
            end else if (offset_ff >= POS_V6_DST_HI && offset_ff < POS_V6_DST_LO) begin
               dst_hi_in = {dst_hi_ff[ADDR_WIDTH-9:0], frame_byte};
            end else if (offset_ff >= POS_V6_DST_LO && offset_ff < POS_V6_END) begin
               dst_lo_in = {dst_lo_ff[ADDR_WIDTH-9:0], frame_byte};
            end else if (offset_ff == port_base || offset_ff == port_base + 16'd1) begin
               port0_in = {port0_ff[7:0], frame_byte};
            end else if (offset_ff == port_base + 16'd2 ||
                         offset_ff == port_base + 16'd3) begin
               port1_in = {port1_ff[7:0], frame_byte};
            end
         end
      end

      offset_in = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + 16'd1;
   end

   // Result for a frame ending at this byte. The frame length is offset + 1, so
   // "length >= n" is tested as "offset >= n - 1".
   always_comb begin
      result        = '0;
      result.l3_kind = L3_NONE;
      result.l4_kind = L4_NONE;
      has_l4        = 1'b0;
      l4_pos        = POS_V6_END;
      if (ether_in == ETHER_IPV4 && offset_ff >= POS_V4_END - 16'd1) begin
         result.l3_kind = L3_IPV4;
         has_l4         = (ihl_in >= IHL_MIN);
         l4_pos         = POS_L3_START + {10'd0, ihl_in, 2'b00};
      end else if (ether_in == ETHER_IPV6 && offset_ff >= POS_V6_END - 16'd1) begin
         result.l3_kind = L3_IPV6;
         has_l4         = 1'b1;
      end
      if (has_l4) begin
         if (proto_in == PROTO_TCP &&
             offset_ff >= l4_pos + {8'd0, TCP_HDR_LEN} - 16'd1) begin
            result.l4_kind = L4_TCP;
         end else if (proto_in == PROTO_UDP &&
                      offset_ff >= l4_pos + {8'd0, UDP_HDR_LEN} - 16'd1) begin
            result.l4_kind = L4_UDP;
         end
      end
      if (result.l3_kind != L3_NONE) begin
         result.src_addr_high = src_hi_in;
         result.src_addr_low  = src_lo_in;
         result.dst_addr_high = dst_hi_in;
         result.dst_addr_low  = dst_lo_in;
      end
      if (result.l4_kind != L4_NONE) begin
         result.src_port = port0_in;
         result.dst_port = port1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (take && end_of_frame)) begin
         offset_ff <= '0;
         ether_ff  <= '0;
         proto_ff  <= '0;
         ihl_ff    <= '0;
         src_hi_ff <= '0;
         src_lo_ff <= '0;
         dst_hi_ff <= '0;
         dst_lo_ff <= '0;
         port0_ff  <= '0;
         port1_ff  <= '0;
      end else if (take) begin
         offset_ff <= offset_in;
         ether_ff  <= ether_in;
         proto_ff  <= proto_in;
         ihl_ff    <= ihl_in;
         src_hi_ff <= src_hi_in;
         src_lo_ff <= src_lo_in;
         dst_hi_ff <= dst_hi_in;
         dst_lo_ff <= dst_lo_in;
         port0_ff  <= port0_in;
         port1_ff  <= port1_in;
      end
   end

endmodule

// File: rtl/core/packet_header_field_extractor_core.sv
// Header parser: one frame byte per transaction, one result per frame.
// Throughput is one byte per cycle; a new byte is taken while a result waits,
// unless the result register is full and not being drained.
// Latency: the result appears in the cycle after its end-of-frame byte is taken.
// Synchronous active-high reset clears the offset, all captured fields and
// the result valid flag.
module packet_header_field_extractor_core (
   input  logic       clock,
   input  logic       reset,
   phfx_req_if.sink   req,
   phfx_rsp_if.source rsp
);
   import phfx_pkg::*;

   logic       take;
   logic       rsp_valid_ff;
   result_type result;
   result_type rsp_data_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   phfx_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .frame_byte   (req.frame_byte),
      .end_of_frame (req.end_of_frame),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req.end_of_frame) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req.end_of_frame) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.l3_kind       = rsp_data_ff.l3_kind;
   assign rsp.l4_kind       = rsp_data_ff.l4_kind;
   assign rsp.src_addr_high = rsp_data_ff.src_addr_high;
   assign rsp.src_addr_low  = rsp_data_ff.src_addr_low;
   assign rsp.dst_addr_high = rsp_data_ff.dst_addr_high;
   assign rsp.dst_addr_low  = rsp_data_ff.dst_addr_low;
   assign rsp.src_port      = rsp_data_ff.src_port;
   assign rsp.dst_port      = rsp_data_ff.dst_port;

   // A transport header is only reported on top of a network header.
   a_l4_needs_l3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.l4_kind == L4_NONE || rsp_data_ff.l3_kind != L3_NONE))
      else $error("transport kind reported without network kind");

   a_no_l3_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.l3_kind == L3_NONE) |->
         (rsp_data_ff.src_addr_low == '0 && rsp_data_ff.dst_addr_low == '0 &&
          rsp_data_ff.src_port == '0 && rsp_data_ff.dst_port == '0))
      else $error("fields not cleared for frame without network header");

   a_v4_high_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.l3_kind == L3_IPV4) |->
         (rsp_data_ff.src_addr_high == '0 && rsp_data_ff.dst_addr_high == '0 &&
          rsp_data_ff.src_addr_low[63:32] == '0 && rsp_data_ff.dst_addr_low[63:32] == '0))
      else $error("IPv4 address wider than 32 bits");

   a_eof_result: assert property (@(posedge clock) disable iff (reset)
      (take && req.end_of_frame) |=> rsp_valid_ff)
      else $error("end of frame did not produce a result");

endmodule

// File: bench/tb_packet_header_field_extractor_core.sv
`timescale 1ns / 1ps

module tb_packet_header_field_extractor_core;
   import phfx_pkg::*;

   localparam int unsigned WORD_BYTES = 4;

   typedef logic [7:0] frame_bytes_type[$];

   typedef struct {
      logic [15:0] ether;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      int unsigned frame_len;
      int          fill;
      bit          known_result;
      l3_kind_type known_l3;
      l4_kind_type known_l4;
   } frame_row_type;

   logic clock;
   logic reset;

   phfx_req_if req_bus ();
   phfx_rsp_if rsp_bus ();

   packet_header_field_extractor_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // Header state tracked alongside the block, cleared after every frame.
   logic [15:0] hdr_offset = '0;
   logic [15:0] hdr_ether = '0;
   logic [7:0]  hdr_proto = '0;
   logic [3:0]  hdr_ihl = '0;
   logic [63:0] hdr_src_hi = '0;
   logic [63:0] hdr_src_lo = '0;
   logic [63:0] hdr_dst_hi = '0;
   logic [63:0] hdr_dst_lo = '0;
   logic [15:0] hdr_port_a = '0;
   logic [15:0] hdr_port_b = '0;

   result_type  expected_headers[$];
   int unsigned error_count = 0;
   int unsigned req_idle_pct = 36;
   int unsigned rsp_idle_pct = 77;

   // Fill of -1 means random frame content.
   frame_row_type directed_frames [25] = '{
      '{16'h0000,   4'd0,  8'd0,      1,     -1,  1'b1, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 14,    -1,  1'b1, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 33,    -1,  1'b1, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 34,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 53,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 54,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_UDP, 41,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_UDP, 42,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd15, PROTO_TCP, 94,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd15, PROTO_UDP, 81,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd0,  PROTO_TCP, 60,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd4,  PROTO_UDP, 60,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  8'd1,      60,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 70,    255, 1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_UDP, 50,    0,   1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  PROTO_TCP, 53,    -1,  1'b1, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  PROTO_TCP, 54,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  PROTO_TCP, 74,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  PROTO_UDP, 61,    -1,  1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  PROTO_UDP, 62,    255, 1'b0, L3_NONE, L4_NONE},
      '{ETHER_IPV6, 4'd0,  8'd59,     80,    -1,  1'b0, L3_NONE, L4_NONE},
      '{16'h0806,   4'd5,  PROTO_TCP, 64,    -1,  1'b1, L3_NONE, L4_NONE},
      '{16'hFFFF,   4'd15, 8'hFF,     64,    255, 1'b1, L3_NONE, L4_NONE},
      '{16'h86DC,   4'd5,  PROTO_UDP, 80,    -1,  1'b1, L3_NONE, L4_NONE},
      '{ETHER_IPV4, 4'd5,  PROTO_TCP, 65540, -1,  1'b0, L3_NONE, L4_NONE}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void take_port_byte(int unsigned pos, int unsigned base, logic [7:0] b);
      if (pos == base || pos == base + 1) begin
         hdr_port_a = {hdr_port_a[7:0], b};
      end else if (pos == base + 2 || pos == base + 3) begin
         hdr_port_b = {hdr_port_b[7:0], b};
      end
   endfunction

   // Advances the header state by one byte; returns 1 with the parsed header
   // on the end-of-frame byte.
   function automatic bit parse_header_byte(input logic [7:0] b, input logic last,
                                            output result_type hdr);
      int unsigned pos;
      int unsigned frame_len;
      int unsigned l4_base;
      bit          l4_allowed;
      pos = 32'(hdr_offset);
      l4_base = 0;
      l4_allowed = 1'b0;
      hdr = '0;
      if (pos == POS_ETHER_HI || pos == POS_ETHER_LO) begin
         hdr_ether = {hdr_ether[7:0], b};
      end else if (pos >= POS_L3_START) begin
         if (hdr_ether == ETHER_IPV4) begin
            if (pos == POS_L3_START) begin
               hdr_ihl = b[3:0];
            end else if (pos == POS_V4_PROTO) begin
               hdr_proto = b;
            end else if (pos >= POS_V4_SRC && pos < POS_V4_DST) begin
               hdr_src_lo = {hdr_src_lo[55:0], b};
            end else if (pos >= POS_V4_DST && pos < POS_V4_END) begin
               hdr_dst_lo = {hdr_dst_lo[55:0], b};
            end
            if (hdr_ihl >= IHL_MIN && pos >= POS_V4_END) begin
               take_port_byte(pos, int'(POS_L3_START) + WORD_BYTES * int'(hdr_ihl), b);
            end
         end else if (hdr_ether == ETHER_IPV6) begin
            if (pos == POS_V6_PROTO) begin
               hdr_proto = b;
            end else if (pos >= POS_V6_SRC_HI && pos < POS_V6_SRC_LO) begin
               hdr_src_hi = {hdr_src_hi[55:0], b};
            end else if (pos >= POS_V6_SRC_LO && pos < POS_V6_DST_HI) begin
               hdr_src_lo = {hdr_src_lo[55:0], b};
            end else if (pos >= POS_V6_DST_HI && pos < POS_V6_DST_LO) begin
               hdr_dst_hi = {hdr_dst_hi[55:0], b};
            end else if (pos >= POS_V6_DST_LO && pos < POS_V6_END) begin
               hdr_dst_lo = {hdr_dst_lo[55:0], b};
            end else begin
               take_port_byte(pos, 32'(POS_V6_END), b);
            end
         end
      end
      hdr_offset = (pos >= OFFSET_MAX) ? OFFSET_MAX : 16'(pos + 1);
      if (!last) begin
         return 1'b0;
      end

      // A saturated offset still counts the last byte, so the length reads 65536.
      frame_len = pos + 1;
      if (hdr_ether == ETHER_IPV4 && frame_len >= POS_V4_END) begin
         hdr.l3_kind = L3_IPV4;
         if (hdr_ihl >= IHL_MIN) begin
            l4_base = int'(POS_L3_START) + WORD_BYTES * int'(hdr_ihl);
            l4_allowed = 1'b1;
         end
      end else if (hdr_ether == ETHER_IPV6 && frame_len >= POS_V6_END) begin
         hdr.l3_kind = L3_IPV6;
         l4_base = 32'(POS_V6_END);
         l4_allowed = 1'b1;
      end
      if (l4_allowed) begin
         if (hdr_proto == PROTO_TCP && frame_len >= l4_base + TCP_HDR_LEN) begin
            hdr.l4_kind = L4_TCP;
         end else if (hdr_proto == PROTO_UDP && frame_len >= l4_base + UDP_HDR_LEN) begin
            hdr.l4_kind = L4_UDP;
         end
      end
      if (hdr.l3_kind != L3_NONE) begin
         hdr.src_addr_high = hdr_src_hi;
         hdr.src_addr_low = hdr_src_lo;
         hdr.dst_addr_high = hdr_dst_hi;
         hdr.dst_addr_low = hdr_dst_lo;
      end
      if (hdr.l4_kind != L4_NONE) begin
         hdr.src_port = hdr_port_a;
         hdr.dst_port = hdr_port_b;
      end

      hdr_offset = '0;
      hdr_ether = '0;
      hdr_proto = '0;
      hdr_ihl = '0;
      hdr_src_hi = '0;
      hdr_src_lo = '0;
      hdr_dst_hi = '0;
      hdr_dst_lo = '0;
      hdr_port_a = '0;
      hdr_port_b = '0;
      return 1'b1;
   endfunction

   function automatic frame_bytes_type build_frame(logic [15:0] ether, logic [3:0] ihl,
                                                   logic [7:0] proto, int unsigned frame_len,
                                                   int fill);
      frame_bytes_type f;
      for (int i = 0; i < frame_len; i++) begin
         f.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      end
      if (frame_len > POS_ETHER_HI) f[POS_ETHER_HI] = ether[15:8];
      if (frame_len > POS_ETHER_LO) f[POS_ETHER_LO] = ether[7:0];
      if (ether == ETHER_IPV4) begin
         // The version nibble is ignored by the parser; vary it now and then.
         if (frame_len > POS_L3_START) begin
            f[POS_L3_START] = {($urandom_range(7) == 0) ? 4'($urandom) : 4'h4, ihl};
         end
         if (frame_len > POS_V4_PROTO) f[POS_V4_PROTO] = proto;
      end else if (ether == ETHER_IPV6) begin
         if (frame_len > POS_V6_PROTO) f[POS_V6_PROTO] = proto;
      end
      return f;
   endfunction

   task automatic send_frame(frame_bytes_type f, bit known_result, result_type known_hdr);
      result_type hdr;
      for (int i = 0; i < f.size(); i++) begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.frame_byte <= f[i];
         req_bus.end_of_frame <= (i == f.size() - 1);
         do @(posedge clock); while (!req_bus.ready);
         if (parse_header_byte(f[i], i == f.size() - 1, hdr)) begin
            expected_headers.push_back(known_result ? known_hdr : hdr);
         end
      end
   endtask

   // Holds the sender off until every pending result has been received.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_headers.size() != 0);
   endtask

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Result sink: random backpressure and checking of every accepted transaction.
   initial begin
      result_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_headers.size() == 0) begin
               error_count++;
               $display("%0t: result with no expectation waiting: l3 %0d l4 %0d", $time,
                        rsp_bus.l3_kind, rsp_bus.l4_kind);
            end else begin
               want = expected_headers.pop_front();
               compare_field("l3_kind", 64'(want.l3_kind), 64'(rsp_bus.l3_kind));
               compare_field("l4_kind", 64'(want.l4_kind), 64'(rsp_bus.l4_kind));
               compare_field("src_addr_high", want.src_addr_high, rsp_bus.src_addr_high);
               compare_field("src_addr_low", want.src_addr_low, rsp_bus.src_addr_low);
               compare_field("dst_addr_high", want.dst_addr_high, rsp_bus.dst_addr_high);
               compare_field("dst_addr_low", want.dst_addr_low, rsp_bus.dst_addr_low);
               compare_field("src_port", 64'(want.src_port), 64'(rsp_bus.src_port));
               compare_field("dst_port", 64'(want.dst_port), 64'(rsp_bus.dst_port));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      result_type  known_hdr;
      logic [15:0] ether;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      int unsigned l4_base;
      int unsigned l4_need;
      int unsigned frame_len;
      int unsigned pick;
      int unsigned phase_bytes;
      int unsigned phase_frames;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.frame_byte <= '0;
      req_bus.end_of_frame <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_frames[r]) begin
         known_hdr = '0;
         known_hdr.l3_kind = directed_frames[r].known_l3;
         known_hdr.l4_kind = directed_frames[r].known_l4;
         send_frame(build_frame(directed_frames[r].ether, directed_frames[r].ihl,
                                directed_frames[r].proto, directed_frames[r].frame_len,
                                directed_frames[r].fill),
                    directed_frames[r].known_result, known_hdr);
      end
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 77 : 0;
         rsp_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 36 : 0;
         phase_bytes = 0;
         phase_frames = 0;
         while (phase_bytes < 370 || phase_frames < 16) begin
            pick = $urandom_range(99);
            ihl = 4'($urandom);
            proto = 8'($urandom);
            if (pick < 70) begin
               // IPv4 or IPv6 header with random content; the IHL, protocol and frame length are mostly valid.
               if (pick < 40) begin
                  ether = ETHER_IPV4;
                  if ($urandom_range(4) != 0) ihl = IHL_MIN;
                  l4_base = (ihl >= IHL_MIN) ?
                            int'(POS_L3_START) + WORD_BYTES * int'(ihl) : 32'(POS_V4_END);
               end else begin
                  ether = ETHER_IPV6;
                  l4_base = 32'(POS_V6_END);
               end
               pick = $urandom_range(99);
               if (pick < 45) proto = PROTO_TCP;
               else if (pick < 90) proto = PROTO_UDP;
               l4_need = (proto == PROTO_TCP) ? 32'(TCP_HDR_LEN) : 32'(UDP_HDR_LEN);
               if ($urandom_range(9) < 7) begin
                  frame_len = l4_base + l4_need + $urandom_range(24);
               end else begin
                  frame_len = $urandom_range(l4_base + l4_need + 2, 1);
               end
            end else begin
               ether = (pick < 80) ? 16'($urandom) :
                       (pick < 90) ? ETHER_IPV4 : ETHER_IPV6;
               frame_len = $urandom_range(100, 1);
            end
            send_frame(build_frame(ether, ihl, proto, frame_len, -1), 1'b0, '0);
            phase_bytes += frame_len;
            phase_frames++;
            if ($urandom_range(9) == 0) drain_results();
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
